### design/stt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, token codes, byte codes and the keyword lookup of the
// source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam int KIND_W       = 5;
   localparam int LEN_W        = 16;
   localparam int SLOTS        = 3;
   localparam int KW_MAX_BYTES = 8;

   typedef logic [KIND_W-1:0] kind_type;
   typedef logic [LEN_W-1:0]  length_type;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_INT,
      MODE_STRING,
      MODE_LT,
      MODE_GT,
      MODE_EQ,
      MODE_NOT
   } mode_type;

   localparam kind_type KIND_EOF      = 5'd0;
   localparam kind_type KIND_UNKNOWN  = 5'd1;
   localparam kind_type KIND_LBRACE   = 5'd2;
   localparam kind_type KIND_RBRACE   = 5'd3;
   localparam kind_type KIND_LPAREN   = 5'd4;
   localparam kind_type KIND_RPAREN   = 5'd5;
   localparam kind_type KIND_PLUS     = 5'd6;
   localparam kind_type KIND_MINUS    = 5'd7;
   localparam kind_type KIND_DOT      = 5'd8;
   localparam kind_type KIND_LT       = 5'd9;
   localparam kind_type KIND_LE       = 5'd10;
   localparam kind_type KIND_GT       = 5'd11;
   localparam kind_type KIND_GE       = 5'd12;
   localparam kind_type KIND_EQ       = 5'd13;
   localparam kind_type KIND_EQEQ     = 5'd14;
   localparam kind_type KIND_NOT      = 5'd15;
   localparam kind_type KIND_NE       = 5'd16;
   localparam kind_type KIND_STRING   = 5'd17;
   localparam kind_type KIND_INTEGER  = 5'd18;
   localparam kind_type KIND_BOOL     = 5'd19;
   localparam kind_type KIND_CLASS    = 5'd20;
   localparam kind_type KIND_FUNCTION = 5'd21;
   localparam kind_type KIND_FOR      = 5'd22;
   localparam kind_type KIND_WHILE    = 5'd23;
   localparam kind_type KIND_RETURN   = 5'd24;
   localparam kind_type KIND_IF       = 5'd25;
   localparam kind_type KIND_ELSE     = 5'd26;
   localparam kind_type KIND_CALL     = 5'd27;
   localparam kind_type KIND_LABEL    = 5'd28;

   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BANG   = 8'h21;
   localparam logic [7:0] CHAR_LT     = 8'h3C;
   localparam logic [7:0] CHAR_EQ     = 8'h3D;
   localparam logic [7:0] CHAR_GT     = 8'h3E;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_LBRACE = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE = 8'h7D;

   typedef struct packed {
      logic     hit;
      kind_type kind;
   } kw_result_type;

   // Saturating length increment.
   function automatic length_type grow_length(input length_type len);
      return (len == {LEN_W{1'b1}}) ? len : len + 1'b1;
   endfunction

   // Match the first bytes of an identifier (byte 0 in the low bits) against
   // the keyword list.
   function automatic kw_result_type keyword_lookup(
      input logic [8*KW_MAX_BYTES-1:0] kbuf,
      input length_type                klen
   );
      logic [8*KW_MAX_BYTES-1:0] head;
      kw_result_type             r;
      for (int i = 0; i < KW_MAX_BYTES; i++) begin
         head[8*(KW_MAX_BYTES-1-i) +: 8] = kbuf[8*i +: 8];
      end
      r.hit  = 1'b1;
      r.kind = KIND_LABEL;
      if (klen == 16'd5 && head[63 -: 40] == "class") begin
         r.kind = KIND_CLASS;
      end else if (klen == 16'd8 && head[63 -: 64] == "function") begin
         r.kind = KIND_FUNCTION;
      end else if (klen == 16'd4 && head[63 -: 32] == "true") begin
         r.kind = KIND_BOOL;
      end else if (klen == 16'd5 && head[63 -: 40] == "false") begin
         r.kind = KIND_BOOL;
      end else if (klen == 16'd3 && head[63 -: 24] == "for") begin
         r.kind = KIND_FOR;
      end else if (klen == 16'd5 && head[63 -: 40] == "while") begin
         r.kind = KIND_WHILE;
      end else if (klen == 16'd6 && head[63 -: 48] == "return") begin
         r.kind = KIND_RETURN;
      end else if (klen == 16'd2 && head[63 -: 16] == "if") begin
         r.kind = KIND_IF;
      end else if (klen == 16'd4 && head[63 -: 32] == "else") begin
         r.kind = KIND_ELSE;
      end else if (klen == 16'd3 && head[63 -: 24] == "int") begin
         r.kind = KIND_INTEGER;
      end else if (klen == 16'd6 && head[63 -: 48] == "String") begin
         r.kind = KIND_STRING;
      end else begin
         r.hit = 1'b0;
      end
      return r;
   endfunction

endpackage

### design/stt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_front
// Scanner: takes one byte per cycle while push_ready is high, tracks the lexer
// mode and builds a bundle of up to three tokens (closed token, new token, end of file).
// ----------------------------------------------------------------------------
module stt_front
   import stt_pkg::*;
#(
   parameter int OFFSET_BITS   = 16,
   parameter int KEYWORD_BYTES = 8,
   parameter int TOK_W         = KIND_W + OFFSET_BITS + LEN_W,
   parameter int BUNDLE_W      = SLOTS + SLOTS * TOK_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tlast,
   output logic                push_valid,
   input  logic                push_ready,
   output logic [BUNDLE_W-1:0] push_data
);

   localparam int IDX_W = $clog2(KEYWORD_BYTES);

   logic [7:0]             b;
   logic                   fin;
   logic                   fire;
   logic                   is_letter;
   logic                   is_digit;
   logic                   is_alnum;
   logic                   is_space;
   logic                   is_eq_char;

   mode_type               mode_ff;
   mode_type               mode_mid;
   mode_type               mode_new;
   mode_type               mode_in;
   logic                   consumed;
   logic                   starting;
   logic                   single;

   logic [OFFSET_BITS-1:0] start_ff;
   logic [OFFSET_BITS-1:0] start_new;
   logic [OFFSET_BITS-1:0] start_in;
   length_type             len_ff;
   length_type             len_new;
   length_type             len_in;
   logic                   kposs_ff;
   logic                   kposs_new;
   logic                   kposs_in;
   logic [OFFSET_BITS-1:0] off_ff;
   logic [OFFSET_BITS-1:0] off_in;
   logic [OFFSET_BITS-1:0] next_off;

   logic [7:0]             kbuf_ff [KEYWORD_BYTES];
   logic [7:0]             kbuf_in [KEYWORD_BYTES];
   logic                   kbuf_we;
   logic [IDX_W-1:0]       kbuf_widx;
   logic [8*KW_MAX_BYTES-1:0] kbuf_low_cur;
   logic [8*KW_MAX_BYTES-1:0] kbuf_low_nxt;
   kw_result_type          kw_cur;
   kw_result_type          kw_nxt;
   logic                   room;

   logic                   sw_v;
   kind_type               sw_kind;
   logic [OFFSET_BITS-1:0] sw_start;
   length_type             sw_len;
   kind_type               nw_kind;
   logic                   fl_v;
   kind_type               fl_kind;
   length_type             fl_len;
   kind_type               ident_cur_kind;
   kind_type               ident_nxt_kind;
   logic [TOK_W-1:0]       tok0;
   logic [TOK_W-1:0]       tok1;
   logic [TOK_W-1:0]       tok2;
   logic [SLOTS-1:0]       mask;

   assign b          = req_tdata;
   assign fin        = req_tlast;
   assign req_tready = push_ready;
   assign fire       = req_tvalid && req_tready;

   assign is_letter  = b inside {[8'h61:8'h7A], [8'h41:8'h5A]};
   assign is_digit   = b inside {[8'h30:8'h39]};
   assign is_alnum   = is_letter || is_digit;
   assign is_space   = b inside {8'h20, [8'h09:8'h0D]};
   assign is_eq_char = (b == CHAR_EQ);
   assign next_off   = off_ff + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
   assign room       = (len_ff < LEN_W'(KEYWORD_BYTES));

   // Next scan mode: first what the held token does with this byte, then
   // what a byte not taken by it starts.
   always_comb begin
      consumed = 1'b0;
      mode_mid = MODE_IDLE;
      case (mode_ff)
         MODE_STRING: begin
            consumed = 1'b1;
            mode_mid = (b == CHAR_QUOTE) ? MODE_IDLE : MODE_STRING;
         end
         MODE_IDENT: begin
            consumed = is_alnum;
            mode_mid = is_alnum ? MODE_IDENT : MODE_IDLE;
         end
         MODE_INT: begin
            consumed = is_digit;
            mode_mid = is_digit ? MODE_INT : MODE_IDLE;
         end
         MODE_LT, MODE_GT, MODE_EQ, MODE_NOT: begin
            consumed = is_eq_char;
            mode_mid = MODE_IDLE;
         end
         default: begin
            mode_mid = MODE_IDLE;
         end
      endcase

      starting = !consumed && !is_space;
      single   = 1'b0;
      mode_new = mode_mid;
      if (starting) begin
         if (is_letter) begin
            mode_new = MODE_IDENT;
         end else if (is_digit) begin
            mode_new = MODE_INT;
         end else if (b == CHAR_QUOTE) begin
            mode_new = MODE_STRING;
         end else if (b == CHAR_LT) begin
            mode_new = MODE_LT;
         end else if (b == CHAR_GT) begin
            mode_new = MODE_GT;
         end else if (b == CHAR_EQ) begin
            mode_new = MODE_EQ;
         end else if (b == CHAR_BANG) begin
            mode_new = MODE_NOT;
         end else begin
            single = 1'b1;
         end
      end
      mode_in = fin ? MODE_IDLE : mode_new;
   end

   // Held token fields and keyword buffer.
   always_comb begin
      start_new = start_ff;
      len_new   = len_ff;
      kposs_new = kposs_ff;
      kbuf_we   = 1'b0;
      kbuf_widx = len_ff[IDX_W-1:0];
      if (consumed && (mode_ff == MODE_STRING) && (b != CHAR_QUOTE)) begin
         len_new = grow_length(len_ff);
      end
      if (consumed && (mode_ff == MODE_INT)) begin
         len_new = grow_length(len_ff);
      end
      if (consumed && (mode_ff == MODE_IDENT)) begin
         len_new = grow_length(len_ff);
         if (room) begin
            kbuf_we = 1'b1;
         end else begin
            kposs_new = 1'b0;
         end
      end
      if (starting && !single) begin
         start_new = (b == CHAR_QUOTE) ? next_off : off_ff;
         len_new   = (b == CHAR_QUOTE) ? '0 : LEN_W'(1);
         if (is_letter) begin
            kbuf_we   = 1'b1;
            kbuf_widx = '0;
            kposs_new = 1'b1;
         end
      end
      for (int i = 0; i < KEYWORD_BYTES; i++) begin
         kbuf_in[i] = kbuf_ff[i];
      end
      if (kbuf_we) begin
         kbuf_in[kbuf_widx] = b;
      end
      for (int i = 0; i < KW_MAX_BYTES; i++) begin
         kbuf_low_cur[8*i +: 8] = kbuf_ff[i];
         kbuf_low_nxt[8*i +: 8] = kbuf_in[i];
      end
      start_in = fin ? '0 : start_new;
      len_in   = fin ? '0 : len_new;
      kposs_in = fin ? 1'b0 : kposs_new;
      off_in   = fin ? '0 : next_off;
   end

   assign kw_cur = keyword_lookup(kbuf_low_cur, len_ff);
   assign kw_nxt = keyword_lookup(kbuf_low_nxt, len_new);
   assign ident_cur_kind = (kposs_ff && kw_cur.hit) ? kw_cur.kind :
                           (b == CHAR_LPAREN) ? KIND_CALL : KIND_LABEL;
   assign ident_nxt_kind = (kposs_new && kw_nxt.hit) ? kw_nxt.kind : KIND_LABEL;

   // Token that the held mode closes on this byte.
   always_comb begin
      sw_v     = 1'b0;
      sw_kind  = KIND_UNKNOWN;
      sw_start = start_ff;
      sw_len   = len_ff;
      case (mode_ff)
         MODE_STRING: begin
            sw_v    = (b == CHAR_QUOTE);
            sw_kind = KIND_STRING;
         end
         MODE_IDENT: begin
            sw_v    = !is_alnum;
            sw_kind = ident_cur_kind;
         end
         MODE_INT: begin
            sw_v    = !is_digit;
            sw_kind = KIND_INTEGER;
         end
         MODE_LT: begin
            sw_v    = 1'b1;
            sw_kind = is_eq_char ? KIND_LE : KIND_LT;
            sw_len  = is_eq_char ? LEN_W'(2) : LEN_W'(1);
         end
         MODE_GT: begin
            sw_v    = 1'b1;
            sw_kind = is_eq_char ? KIND_GE : KIND_GT;
            sw_len  = is_eq_char ? LEN_W'(2) : LEN_W'(1);
         end
         MODE_EQ: begin
            sw_v    = 1'b1;
            sw_kind = is_eq_char ? KIND_EQEQ : KIND_EQ;
            sw_len  = is_eq_char ? LEN_W'(2) : LEN_W'(1);
         end
         MODE_NOT: begin
            sw_v    = 1'b1;
            sw_kind = is_eq_char ? KIND_NE : KIND_NOT;
            sw_len  = is_eq_char ? LEN_W'(2) : LEN_W'(1);
         end
         default: begin
            sw_v = 1'b0;
         end
      endcase
   end

   // Single-byte token started by this byte.
   always_comb begin
      case (b)
         CHAR_LBRACE: nw_kind = KIND_LBRACE;
         CHAR_RBRACE: nw_kind = KIND_RBRACE;
         CHAR_LPAREN: nw_kind = KIND_LPAREN;
         CHAR_RPAREN: nw_kind = KIND_RPAREN;
         CHAR_PLUS:   nw_kind = KIND_PLUS;
         CHAR_MINUS:  nw_kind = KIND_MINUS;
         CHAR_DOT:    nw_kind = KIND_DOT;
         default:     nw_kind = KIND_UNKNOWN;
      endcase
   end

   // On the last byte, close whatever is still held; no lookahead here.
   always_comb begin
      fl_v    = fin && (mode_new != MODE_IDLE);
      fl_kind = KIND_UNKNOWN;
      fl_len  = LEN_W'(1);
      case (mode_new)
         MODE_IDENT: begin
            fl_kind = ident_nxt_kind;
            fl_len  = len_new;
         end
         MODE_INT: begin
            fl_kind = KIND_INTEGER;
            fl_len  = len_new;
         end
         MODE_STRING: begin
            fl_kind = KIND_STRING;
            fl_len  = len_new;
         end
         MODE_LT:  fl_kind = KIND_LT;
         MODE_GT:  fl_kind = KIND_GT;
         MODE_EQ:  fl_kind = KIND_EQ;
         MODE_NOT: fl_kind = KIND_NOT;
         default:  fl_kind = KIND_UNKNOWN;
      endcase
   end

   // A single-byte token leaves nothing held, so it never meets a flush.
   assign tok0 = {sw_len, sw_start, sw_kind};
   assign tok1 = single ? {LEN_W'(1), off_ff, nw_kind} : {fl_len, start_new, fl_kind};
   assign tok2 = {{LEN_W{1'b0}}, next_off, KIND_EOF};
   assign mask = {fin, single || fl_v, sw_v};

   assign push_valid = fire && (mask != '0);
   assign push_data  = {tok2, tok1, tok0, mask};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         start_ff <= '0;
         len_ff   <= '0;
         kposs_ff <= 1'b0;
         off_ff   <= '0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         kposs_ff <= kposs_in;
         off_ff   <= off_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         for (int i = 0; i < KEYWORD_BYTES; i++) begin
            kbuf_ff[i] <= kbuf_in[i];
         end
      end
   end

endmodule

### design/stt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_queue
// Short first-in first-out queue of token bundles between scanner and
// token sender.
// ----------------------------------------------------------------------------
module stt_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff;
   logic [PTR_W-1:0] wr_in;
   logic [PTR_W-1:0] rd_ff;
   logic [PTR_W-1:0] rd_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = store_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ff] <= in_data;
      end
   end

endmodule

### design/stt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_back
// Token sender: unpacks each bundle and drives its tokens one per cycle while
// rsp_tready is high, through the output register.
// ----------------------------------------------------------------------------
module stt_back
   import stt_pkg::*;
#(
   parameter int TOK_W    = 37,
   parameter int BUNDLE_W = SLOTS + SLOTS * TOK_W,
   parameter int DATA_W   = 40
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  logic [BUNDLE_W-1:0] pop_data,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [DATA_W-1:0]   rsp_tdata,
   output logic                rsp_tlast
);

   logic [SLOTS-1:0]       mask_ff;
   logic [SLOTS-1:0]       mask_in;
   logic [SLOTS-1:0]       mask_left;
   logic [SLOTS*TOK_W-1:0] toks_ff;
   logic [SLOTS*TOK_W-1:0] toks_in;
   logic [SLOTS-1:0]       sel;
   logic [TOK_W-1:0]       sel_tok;
   logic                   can_load;
   logic                   load;
   logic                   take;

   logic                   valid_ff;
   logic                   valid_in;
   logic [TOK_W-1:0]       data_ff;
   logic                   last_ff;

   // Pick the lowest slot still pending; the end-of-file slot is the last.
   always_comb begin
      sel     = '0;
      sel_tok = toks_ff[2*TOK_W +: TOK_W];
      if (mask_ff[0]) begin
         sel[0]  = 1'b1;
         sel_tok = toks_ff[0 +: TOK_W];
      end else if (mask_ff[1]) begin
         sel[1]  = 1'b1;
         sel_tok = toks_ff[TOK_W +: TOK_W];
      end else begin
         sel[2]  = mask_ff[2];
      end
   end

   assign can_load  = !valid_ff || rsp_tready;
   assign load      = can_load && (mask_ff != '0);
   assign mask_left = load ? (mask_ff & ~sel) : mask_ff;
   assign pop_ready = (mask_left == '0);
   assign take      = pop_valid && pop_ready;
   assign mask_in   = take ? pop_data[SLOTS-1:0] : mask_left;
   assign toks_in   = take ? pop_data[BUNDLE_W-1:SLOTS] : toks_ff;
   assign valid_in  = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         mask_ff  <= mask_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      toks_ff <= toks_in;
      if (load) begin
         data_ff <= sel_tok;
         last_ff <= sel[2];
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = DATA_W'(data_ff);
   assign rsp_tlast  = last_ff;

endmodule

### design/source_text_tokenizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_top
// Streaming lexer: source bytes in, tokens (kind, start, length) out.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one source byte per item; req_tlast marks the last byte.
//   rsp_*  carries one token per item; rsp_tlast marks the end-of-file token,
//          which follows every text and resets offsets to 0 for the next one.
// Throughput: one byte per cycle. A byte yields zero to three tokens, and
//   the token sender drives one token per cycle, so bytes that yield more
//   than one token are absorbed by the bundle queue (QUEUE_DEPTH bundles);
//   req_tready drops only when that queue is full.
// Path: a byte's tokens pass the bundle queue, the sender's bundle register
//   and the output register, then leave one per cycle while rsp_tready is high.
// Reset: synchronous; clears the scan mode, the offset, the queue and the
//   output register. No clearing pass is needed.
// Stall: while rsp_tready is low the output token holds, the queue fills,
//   and then input is back-pressured. No token is lost or repeated.
// ----------------------------------------------------------------------------
module source_text_tokenizer_top
   import stt_pkg::*;
#(
   parameter int OFFSET_BITS   = 16,
   parameter int KEYWORD_BYTES = 8,
   parameter int QUEUE_DEPTH   = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,  // text_byte
   input  logic req_tlast,        // final_byte
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // token_kind, token_start, token_length (low to high), zero padded
   output logic [((KIND_W + OFFSET_BITS + LEN_W + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic rsp_tlast         // final_token
);

   localparam int TOK_W    = KIND_W + OFFSET_BITS + LEN_W;
   localparam int BUNDLE_W = SLOTS + SLOTS * TOK_W;
   localparam int DATA_W   = ((TOK_W + 7) / 8) * 8;

   logic                push_valid;
   logic                push_ready;
   logic [BUNDLE_W-1:0] push_data;
   logic                pop_valid;
   logic                pop_ready;
   logic [BUNDLE_W-1:0] pop_data;

   stt_front #(
      .OFFSET_BITS   (OFFSET_BITS),
      .KEYWORD_BYTES (KEYWORD_BYTES),
      .TOK_W         (TOK_W),
      .BUNDLE_W      (BUNDLE_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   stt_queue #(
      .WIDTH (BUNDLE_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   stt_back #(
      .TOK_W    (TOK_W),
      .BUNDLE_W (BUNDLE_W),
      .DATA_W   (DATA_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### dv/source_text_tokenizer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_top_test
// Streams source text into the tokenizer one byte per item. Each accepted
// byte runs through a cycle-free lexer model kept here, and the tokens that
// model produces (typed in the table for single-byte texts) are queued. Every
// token leaving the block is compared field by field with the oldest queued
// one. A short directed table comes first: single-byte texts, every punctuation
// mark, every operator but a lone =, and two strings left open until the end of
// their text. Random texts built from keywords, identifiers, numbers, strings,
// operators and noise follow. Both sides idle in random bursts, and the token
// side holds off once for a long stretch so the block has to stall its input.
// ----------------------------------------------------------------------------
module source_text_tokenizer_top_test;
   import stt_pkg::*;

   localparam int OFFSET_W      = 16;
   localparam int RSP_W         = ((KIND_W + OFFSET_W + LEN_W + 7) / 8) * 8;
   localparam int RANDOM_BYTES  = 75;
   localparam int CALM_BYTES    = 25;
   localparam int HOLD_CYCLES   = 60;
   localparam int DRAIN_CYCLES  = 24;
   localparam int LONG_BODY     = 6;
   localparam int PRINT_LIMIT   = 50;

   typedef struct packed {
      kind_type            kind;
      logic [OFFSET_W-1:0] start;
      length_type          length;
      logic                is_eof;
   } token_t;

   typedef struct packed {
      logic [7:0]  text_byte;
      logic        final_byte;
      int unsigned copies;
      logic [1:0]  typed_count;
      token_t      typed_first;
      token_t      typed_second;
   } stim_row_t;

   localparam token_t NO_TOK = '0;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata = 8'h00;
   logic             req_tlast = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;

   // lexer model state
   mode_type            lex_mode;
   logic [OFFSET_W-1:0] tok_start;
   length_type          tok_len;
   logic [7:0]          kw_buf [KW_MAX_BYTES];
   logic [OFFSET_W-1:0] text_pos;
   bit                  kw_candidate;
   token_t              step_tokens[$];

   token_t     tokens_due[$];
   logic [7:0] text_q[$];
   int         mismatches = 0;
   int         tokens_checked = 0;
   int         texts_seen = 0;
   int         bytes_sent = 0;
   int         longest_token = 0;
   bit [28:0]  kinds_seen = '0;
   bit         calm = 1'b0;
   bit         hold_off = 1'b0;

   string keyword_names [11] = '{"class", "function", "true", "false", "for", "while",
                                 "return", "if", "else", "int", "String"};
   string operator_texts [8] = '{"<=", ">=", "==", "!=", "<", ">", "=", "!"};
   string punct_chars = "{}()+-.";
   logic [7:0] blank_bytes [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

   source_text_tokenizer_top #(
      .OFFSET_BITS(OFFSET_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic token_t tok(input kind_type k, input logic [OFFSET_W-1:0] s,
                                  input length_type l, input logic e);
      token_t t;
      t.kind   = k;
      t.start  = s;
      t.length = l;
      t.is_eof = e;
      return t;
   endfunction

   function automatic stim_row_t plan_row(input logic [7:0] b, input logic last_byte,
                                          input int unsigned copies, input logic [1:0] n,
                                          input token_t t0, input token_t t1);
      stim_row_t r;
      r.text_byte    = b;
      r.final_byte   = last_byte;
      r.copies       = copies;
      r.typed_count  = n;
      r.typed_first  = t0;
      r.typed_second = t1;
      return r;
   endfunction

   function automatic bit is_letter(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic bit is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic length_type bump(input length_type len);
      return (len == '1) ? len : len + length_type'(1);
   endfunction

   function automatic void clear_lexer();
      lex_mode     = MODE_IDLE;
      tok_start    = '0;
      tok_len      = '0;
      text_pos     = '0;
      kw_candidate = 1'b0;
   endfunction

   // Keyword when the whole word is in the buffer, else call or label.
   function automatic kind_type word_kind(input bit paren_next);
      string    w;
      kind_type k;
      k = paren_next ? KIND_CALL : KIND_LABEL;
      if (kw_candidate) begin
         w = "";
         for (int i = 0; i < int'(tok_len); i++) w = $sformatf("%s%c", w, kw_buf[i]);
         case (w)
            "class":    k = KIND_CLASS;
            "function": k = KIND_FUNCTION;
            "true":     k = KIND_BOOL;
            "false":    k = KIND_BOOL;
            "for":      k = KIND_FOR;
            "while":    k = KIND_WHILE;
            "return":   k = KIND_RETURN;
            "if":       k = KIND_IF;
            "else":     k = KIND_ELSE;
            "int":      k = KIND_INTEGER;
            "String":   k = KIND_STRING;
            default: ;
         endcase
      end
      return k;
   endfunction

   function automatic kind_type compare_kind(input mode_type m, input bit with_eq);
      case (m)
         MODE_LT: return with_eq ? KIND_LE : KIND_LT;
         MODE_GT: return with_eq ? KIND_GE : KIND_GT;
         MODE_EQ: return with_eq ? KIND_EQEQ : KIND_EQ;
         default: return with_eq ? KIND_NE : KIND_NOT;
      endcase
   endfunction

   function automatic void close_pending(input bit paren_next);
      case (lex_mode)
         MODE_IDENT:
            step_tokens.push_back(tok(word_kind(paren_next), tok_start, tok_len, 1'b0));
         MODE_INT:    step_tokens.push_back(tok(KIND_INTEGER, tok_start, tok_len, 1'b0));
         MODE_STRING: step_tokens.push_back(tok(KIND_STRING, tok_start, tok_len, 1'b0));
         MODE_LT, MODE_GT, MODE_EQ, MODE_NOT:
            step_tokens.push_back(tok(compare_kind(lex_mode, 1'b0), tok_start, 1, 1'b0));
         default: ;
      endcase
      lex_mode = MODE_IDLE;
   endfunction

   // Advance the lexer model by one byte; the tokens it yields land in step_tokens.
   function automatic void lex_byte(input logic [7:0] b, input logic last_byte);
      logic [OFFSET_W-1:0] here;
      logic [OFFSET_W-1:0] next_pos;
      bit                  taken;
      mode_type            opened;
      kind_type            k;
      here     = text_pos;
      next_pos = text_pos + 1'b1;
      taken    = 1'b0;
      step_tokens.delete();
      case (lex_mode)
         MODE_STRING: begin
            taken = 1'b1;
            if (b == CHAR_QUOTE) begin
               step_tokens.push_back(tok(KIND_STRING, tok_start, tok_len, 1'b0));
               lex_mode = MODE_IDLE;
            end else begin
               tok_len = bump(tok_len);
            end
         end
         MODE_IDENT: begin
            if (is_letter(b) || is_digit(b)) begin
               if (tok_len < length_type'(KW_MAX_BYTES)) kw_buf[tok_len] = b;
               else kw_candidate = 1'b0;
               tok_len = bump(tok_len);
               taken   = 1'b1;
            end else begin
               close_pending(b == CHAR_LPAREN);
            end
         end
         MODE_INT: begin
            if (is_digit(b)) begin
               tok_len = bump(tok_len);
               taken   = 1'b1;
            end else begin
               close_pending(1'b0);
            end
         end
         MODE_LT, MODE_GT, MODE_EQ, MODE_NOT: begin
            if (b == CHAR_EQ) begin
               step_tokens.push_back(tok(compare_kind(lex_mode, 1'b1), tok_start, 2, 1'b0));
               lex_mode = MODE_IDLE;
               taken    = 1'b1;
            end else begin
               close_pending(1'b0);
            end
         end
         default: ;
      endcase

      if (!taken && !(b == 8'h20 || (b >= 8'h09 && b <= 8'h0D))) begin
         opened = MODE_IDLE;
         k      = KIND_UNKNOWN;
         case (b)
            CHAR_QUOTE:  opened = MODE_STRING;
            CHAR_LT:     opened = MODE_LT;
            CHAR_GT:     opened = MODE_GT;
            CHAR_EQ:     opened = MODE_EQ;
            CHAR_BANG:   opened = MODE_NOT;
            CHAR_LBRACE: k = KIND_LBRACE;
            CHAR_RBRACE: k = KIND_RBRACE;
            CHAR_LPAREN: k = KIND_LPAREN;
            CHAR_RPAREN: k = KIND_RPAREN;
            CHAR_PLUS:   k = KIND_PLUS;
            CHAR_MINUS:  k = KIND_MINUS;
            CHAR_DOT:    k = KIND_DOT;
            default: ;
         endcase
         if (is_letter(b)) opened = MODE_IDENT;
         if (is_digit(b)) opened = MODE_INT;
         if (opened == MODE_IDLE) begin
            step_tokens.push_back(tok(k, here, 1, 1'b0));
         end else begin
            lex_mode     = opened;
            // string text starts past the opening quote
            tok_start    = (opened == MODE_STRING) ? next_pos : here;
            tok_len      = (opened == MODE_STRING) ? length_type'(0) : length_type'(1);
            kw_buf[0]    = b;
            kw_candidate = 1'b1;
         end
      end

      if (last_byte) begin
         close_pending(1'b0);
         step_tokens.push_back(tok(KIND_EOF, next_pos, 0, 1'b1));
         clear_lexer();
      end else begin
         text_pos = next_pos;
      end
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_LIMIT) $display("MISMATCH %s", msg);
      mismatches++;
   endtask

   // Offer one byte, wait for the handshake, then queue the tokens it yields.
   task automatic send_byte(input logic [7:0] b, input logic last_byte, input bit gap_ok,
                            input logic [1:0] typed_count, input token_t typed_first,
                            input token_t typed_second);
      if (gap_ok && !calm && !hold_off && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last_byte;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      lex_byte(b, last_byte);
      if (typed_count == 2'd0) begin
         foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
      end else begin
         tokens_due.push_back(typed_first);
         if (typed_count > 2'd1) tokens_due.push_back(typed_second);
      end
      bytes_sent++;
      @(negedge clock);
   endtask

   function automatic void append_text(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endfunction

   function automatic logic [7:0] random_letter();
      return 8'h41 + 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'h20 : 8'h00);
   endfunction

   function automatic logic [7:0] random_digit();
      return 8'h30 + 8'($urandom_range(0, 9));
   endfunction

   // token side: random stalls, plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_off = 1'b0;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(0, 18);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      token_t got;
      token_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = tok(rsp_tdata[0 +: KIND_W], rsp_tdata[KIND_W +: OFFSET_W],
                   rsp_tdata[KIND_W + OFFSET_W +: LEN_W], rsp_tlast);
         tokens_checked++;
         if (got.kind <= KIND_LABEL) kinds_seen[got.kind] = 1'b1;
         if (int'(got.length) > longest_token) longest_token = int'(got.length);
         if (got.is_eof === 1'b1) texts_seen++;
         if (tokens_due.size() == 0) begin
            report_mismatch($sformatf("token %0d: kind %0d start %0d arrived with none due",
                                      tokens_checked, got.kind, got.start));
         end else begin
            want = tokens_due.pop_front();
            if (got.kind !== want.kind)
               report_mismatch($sformatf("token %0d: kind %0d, expected %0d",
                                         tokens_checked, got.kind, want.kind));
            if (got.start !== want.start)
               report_mismatch($sformatf("token %0d: start %0d, expected %0d",
                                         tokens_checked, got.start, want.start));
            if (got.length !== want.length)
               report_mismatch($sformatf("token %0d: length %0d, expected %0d",
                                         tokens_checked, got.length, want.length));
            if (got.is_eof !== want.is_eof)
               report_mismatch($sformatf("token %0d: last flag %0b, expected %0b",
                                         tokens_checked, got.is_eof, want.is_eof));
         end
      end
   end

   initial begin
      stim_row_t directed_rows[$];
      string     directed_texts [2];
      int        random_bytes;
      int        pieces;
      int        n;
      bit        held_once;

      clear_lexer();
      directed_texts[0] = "f9(!=<>=>\"ab";
      directed_texts[1] = "{}).-!x<===1";
      random_bytes = 0;
      held_once    = 1'b0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single-byte texts: whitespace only, NUL, top byte, punctuation
      directed_rows.push_back(plan_row(8'h20, 1'b1, 1, 2'd1,
                                       tok(KIND_EOF, 1, 0, 1'b1), NO_TOK));
      directed_rows.push_back(plan_row(8'h00, 1'b1, 1, 2'd2,
                                       tok(KIND_UNKNOWN, 0, 1, 1'b0), tok(KIND_EOF, 1, 0, 1'b1)));
      directed_rows.push_back(plan_row(8'hFF, 1'b1, 1, 2'd2,
                                       tok(KIND_UNKNOWN, 0, 1, 1'b0), tok(KIND_EOF, 1, 0, 1'b1)));
      directed_rows.push_back(plan_row(CHAR_PLUS, 1'b1, 1, 2'd2,
                                       tok(KIND_PLUS, 0, 1, 1'b0), tok(KIND_EOF, 1, 0, 1'b1)));
      foreach (directed_texts[t]) begin
         for (int i = 0; i < directed_texts[t].len(); i++)
            directed_rows.push_back(plan_row(directed_texts[t][i],
                                             i == directed_texts[t].len() - 1, 1, 2'd0,
                                             NO_TOK, NO_TOK));
      end
      // string still open when its text ends
      directed_rows.push_back(plan_row(CHAR_QUOTE, 1'b0, 1, 2'd0, NO_TOK, NO_TOK));
      directed_rows.push_back(plan_row("a", 1'b1, LONG_BODY, 2'd0, NO_TOK, NO_TOK));

      foreach (directed_rows[r]) begin
         for (int c = 0; c < int'(directed_rows[r].copies); c++)
            send_byte(directed_rows[r].text_byte,
                      directed_rows[r].final_byte && c == int'(directed_rows[r].copies) - 1,
                      c == 0, directed_rows[r].typed_count,
                      directed_rows[r].typed_first, directed_rows[r].typed_second);
      end

      while (random_bytes < RANDOM_BYTES) begin
         text_q.delete();
         pieces = $urandom_range(2, 8);
         for (int p = 0; p < pieces; p++) begin
            case ($urandom_range(0, 9))
               0, 1: append_text(keyword_names[$urandom_range(0, 10)]);
               2: begin
                  n = $urandom_range(1, 12);
                  text_q.push_back(random_letter());
                  repeat (n - 1)
                     text_q.push_back($urandom_range(0, 3) == 0 ? random_digit() :
                                                                  random_letter());
               end
               3: repeat ($urandom_range(1, 5)) text_q.push_back(random_digit());
               4: begin
                  text_q.push_back(CHAR_QUOTE);
                  repeat ($urandom_range(0, 6)) text_q.push_back(8'($urandom_range(35, 126)));
                  // leave the last string of a text open now and then
                  if (p != pieces - 1 || $urandom_range(0, 1) == 1) text_q.push_back(CHAR_QUOTE);
               end
               5: append_text(operator_texts[$urandom_range(0, 7)]);
               6: text_q.push_back(punct_chars[$urandom_range(0, 6)]);
               7: begin
                  append_text(keyword_names[$urandom_range(0, 10)]);
                  if ($urandom_range(0, 1) == 1) text_q.push_back(random_letter());
                  text_q.push_back(CHAR_LPAREN);
               end
               8: repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(0, 255)));
               default: text_q.push_back(blank_bytes[$urandom_range(0, 5)]);
            endcase
            if ($urandom_range(0, 2) != 0) text_q.push_back(blank_bytes[$urandom_range(0, 5)]);
         end
         foreach (text_q[i]) begin
            send_byte(text_q[i], i == text_q.size() - 1, 1'b1, 2'd0, NO_TOK, NO_TOK);
            random_bytes++;
            if (!held_once && random_bytes >= 20) begin
               hold_off  = 1'b1;
               held_once = 1'b1;
            end
            calm = random_bytes >= RANDOM_BYTES - CALM_BYTES;
         end
      end

      req_tvalid <= 1'b0;
      while (tokens_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d bytes in %0d texts, %0d tokens of %0d distinct kinds",
               bytes_sent, texts_seen, tokens_checked, $countones(kinds_seen));
      $display("longest token %0d bytes, %0d mismatches", longest_token, mismatches);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
